// File: rtl/ast_pkg.sv
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and constants of the three-method array sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package ast_pkg;

  localparam int MAX_ELEMS_DEF = 64;
  localparam int ELEM_W        = 32;
  localparam int METHOD_W      = 2;

  typedef enum logic [METHOD_W-1:0] {
    METH_BUBBLE    = 2'd0,
    METH_SELECTION = 2'd1,
    METH_INSERTION = 2'd2,
    METH_INVALID   = 2'd3
  } method_t;

  typedef enum logic [1:0] {
    WSEL_IN,
    WSEL_QA,
    WSEL_QB
  } wsel_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PAIR_RD,
    ST_PAIR_CMP,
    ST_SWAP_LO,
    ST_SWAP_HI,
    ST_INS_LD,
    ST_INS_CK,
    ST_INS_CMP,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  rd_a_en;
    logic  rd_b_en;
    logic  wr_en;
    wsel_t wr_sel;
    logic  out_load;
    logic  out_end;
    logic  out_invalid;
    logic  out_overflow;
  } ast_cmd_t;

endpackage

`default_nettype wire

// File: rtl/ast_datapath.sv
// ----------------------------------------------------------------------------
// ast_datapath
// Element memory, registered read ports, signed compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ast_datapath
  import ast_pkg::*;
#(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
  input  wire logic                                  clk,
  input  wire ast_cmd_t                              cmd,
  input  wire logic [$clog2(MAX_ELEMS)-1:0]          rd_a_addr,
  input  wire logic [$clog2(MAX_ELEMS)-1:0]          rd_b_addr,
  input  wire logic [$clog2(MAX_ELEMS)-1:0]          wr_addr,
  input  wire logic signed [ELEM_W-1:0]              in_value,
  output logic                                       a_gt_b,
  output logic signed [ELEM_W-1:0]                   out_sorted_value,
  output logic                                       out_end_of_set,
  output logic                                       out_method_invalid,
  output logic                                       out_overflowed
);

  logic signed [ELEM_W-1:0] mem [MAX_ELEMS];
  logic signed [ELEM_W-1:0] qa_r;
  logic signed [ELEM_W-1:0] qb_r;
  logic signed [ELEM_W-1:0] wr_data;
  logic signed [ELEM_W-1:0] res_value_r;
  logic                     res_end_r;
  logic                     res_invalid_r;
  logic                     res_overflow_r;

  always_comb begin
    case (cmd.wr_sel)
      WSEL_QA: wr_data = qa_r;
      WSEL_QB: wr_data = qb_r;
      default: wr_data = in_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_a_en) begin
      qa_r <= mem[rd_a_addr];
    end
    if (cmd.rd_b_en) begin
      qb_r <= mem[rd_b_addr];
    end
  end

  assign a_gt_b = (qa_r > qb_r);

  // Result register: holds while the beat is stalled.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_value_r    <= qa_r;
      res_end_r      <= cmd.out_end;
      res_invalid_r  <= cmd.out_invalid;
      res_overflow_r <= cmd.out_overflow;
    end
  end

  assign out_sorted_value   = res_value_r;
  assign out_end_of_set     = res_end_r;
  assign out_method_invalid = res_invalid_r;
  assign out_overflowed     = res_overflow_r;

endmodule

`default_nettype wire

// File: rtl/ast_ctrl.sv
// ----------------------------------------------------------------------------
// ast_ctrl
// Sequencer for load, bubble / selection / insertion passes and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module ast_ctrl
  import ast_pkg::*;
#(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  input  wire logic                                  in_last,
  output logic                                       in_stall,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [METHOD_W-1:0]                   cfg_wr_data,
  input  wire logic                                  a_gt_b,
  output ast_cmd_t                                   cmd,
  output logic [$clog2(MAX_ELEMS)-1:0]               rd_a_addr,
  output logic [$clog2(MAX_ELEMS)-1:0]               rd_b_addr,
  output logic [$clog2(MAX_ELEMS)-1:0]               wr_addr
);

  localparam int AW = $clog2(MAX_ELEMS);
  localparam int CW = $clog2(MAX_ELEMS + 1);
  localparam int XW = CW + 1;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   i_r, i_nxt;
  logic [AW-1:0]   j_r, j_nxt;
  logic [CW-1:0]   lim_r, lim_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  method_t         meth_r, meth_nxt;
  method_t         cfg_meth_r;

  logic [CW-1:0]   cnt_new;
  logic            in_acc;
  logic            has_room;

  // Loop bounds, compared one bit wider so sums never wrap.
  logic            bub_more_k;
  logic            bub_more_pass;
  logic            sel_more_j;
  logic            sel_more_i;
  logic            ins_more;
  logic            last_elem;

  // Next position after one compare of a bubble or selection step.
  state_t          adv_state;
  logic [AW-1:0]   adv_i;
  logic [AW-1:0]   adv_j;
  logic [CW-1:0]   adv_lim;

  assign in_acc    = in_valid && (state_r == ST_LOAD);
  assign has_room  = (cnt_r < CW'(MAX_ELEMS));
  assign cnt_new   = has_room ? cnt_r + CW'(1) : cnt_r;

  assign bub_more_k    = (XW'(i_r) + XW'(1)) < XW'(lim_r);
  assign bub_more_pass = (lim_r > CW'(1));
  assign sel_more_j    = (XW'(j_r) + XW'(1)) < XW'(cnt_r);
  assign sel_more_i    = (XW'(i_r) + XW'(2)) < XW'(cnt_r);
  assign ins_more      = (XW'(i_r) + XW'(1)) < XW'(cnt_r);
  assign last_elem     = (XW'(i_r) + XW'(1)) == XW'(cnt_r);

  always_comb begin
    adv_state = ST_PAIR_RD;
    adv_i     = i_r;
    adv_j     = j_r;
    adv_lim   = lim_r;
    if (meth_r == METH_BUBBLE) begin
      if (bub_more_k) begin
        adv_i = i_r + AW'(1);
        adv_j = j_r + AW'(1);
      end else if (bub_more_pass) begin
        adv_lim = lim_r - CW'(1);
        adv_i   = '0;
        adv_j   = AW'(1);
      end else begin
        adv_state = ST_OUT_RD;
        adv_i     = '0;
      end
    end else begin
      if (sel_more_j) begin
        adv_j = j_r + AW'(1);
      end else if (sel_more_i) begin
        adv_i = i_r + AW'(1);
        adv_j = i_r + AW'(2);
      end else begin
        adv_state = ST_OUT_RD;
        adv_i     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      i_r        <= '0;
      j_r        <= '0;
      lim_r      <= '0;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      meth_r     <= METH_BUBBLE;
      cfg_meth_r <= METH_BUBBLE;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      lim_r   <= lim_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      meth_r  <= meth_nxt;
      if (cfg_wr_en) begin
        cfg_meth_r <= method_t'(cfg_wr_data);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    lim_nxt   = lim_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    meth_nxt  = meth_r;
    cmd       = '0;
    cmd.wr_sel = WSEL_IN;
    rd_a_addr = i_r;
    rd_b_addr = j_r;
    wr_addr   = i_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;

    case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        wr_addr  = cnt_r[AW-1:0];
        if (in_acc) begin
          if (has_room) begin
            cmd.wr_en = 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          cnt_nxt = cnt_new;
          if (in_last) begin
            meth_nxt = cfg_meth_r;
            i_nxt    = '0;
            j_nxt    = AW'(1);
            lim_nxt  = cnt_new - CW'(1);
            if (cfg_meth_r == METH_INVALID || cnt_new < CW'(2)) begin
              state_nxt = ST_OUT_RD;
            end else if (cfg_meth_r == METH_INSERTION) begin
              i_nxt     = AW'(1);
              state_nxt = ST_INS_LD;
            end else begin
              state_nxt = ST_PAIR_RD;
            end
          end
        end
      end

      ST_PAIR_RD: begin
        cmd.rd_a_en = 1'b1;
        cmd.rd_b_en = 1'b1;
        state_nxt   = ST_PAIR_CMP;
      end

      ST_PAIR_CMP: begin
        if (a_gt_b) begin
          state_nxt = ST_SWAP_LO;
        end else begin
          state_nxt = adv_state;
          i_nxt     = adv_i;
          j_nxt     = adv_j;
          lim_nxt   = adv_lim;
        end
      end

      ST_SWAP_LO: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WSEL_QB;
        wr_addr    = i_r;
        state_nxt  = ST_SWAP_HI;
      end

      ST_SWAP_HI: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WSEL_QA;
        wr_addr    = j_r;
        state_nxt  = adv_state;
        i_nxt      = adv_i;
        j_nxt      = adv_j;
        lim_nxt    = adv_lim;
      end

      ST_INS_LD: begin
        // Hold the element being inserted in read port B.
        cmd.rd_b_en = 1'b1;
        rd_b_addr   = i_r;
        j_nxt       = i_r;
        state_nxt   = ST_INS_CK;
      end

      ST_INS_CK: begin
        if (j_r == '0) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WSEL_QB;
          wr_addr    = j_r;
          if (ins_more) begin
            i_nxt     = i_r + AW'(1);
            state_nxt = ST_INS_LD;
          end else begin
            i_nxt     = '0;
            state_nxt = ST_OUT_RD;
          end
        end else begin
          cmd.rd_a_en = 1'b1;
          rd_a_addr   = j_r - AW'(1);
          state_nxt   = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        cmd.wr_en = 1'b1;
        wr_addr   = j_r;
        if (a_gt_b) begin
          cmd.wr_sel = WSEL_QA;
          j_nxt      = j_r - AW'(1);
          state_nxt  = ST_INS_CK;
        end else begin
          cmd.wr_sel = WSEL_QB;
          if (ins_more) begin
            i_nxt     = i_r + AW'(1);
            state_nxt = ST_INS_LD;
          end else begin
            i_nxt     = '0;
            state_nxt = ST_OUT_RD;
          end
        end
      end

      ST_OUT_RD: begin
        cmd.rd_a_en = 1'b1;
        rd_a_addr   = i_r;
        state_nxt   = ST_OUT_LD;
      end

      ST_OUT_LD: begin
        cmd.out_load     = 1'b1;
        cmd.out_end      = last_elem;
        cmd.out_invalid  = (meth_r == METH_INVALID);
        cmd.out_overflow = ovf_r;
        state_nxt        = ST_OUT_HOLD;
      end

      ST_OUT_HOLD: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (last_elem) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/array_sorter_three_methods.sv
// ----------------------------------------------------------------------------
// array_sorter_three_methods
// Collects a set of signed 32-bit elements and emits it in ascending order,
// or in arrival order for the invalid method.
// Elements arrive one beat per cycle on the in_ channel while in_stall is
// low and are written to an element memory of MAX_ELEMS words; beats
// beyond capacity are dropped and flagged on every result of that set.
// The beat marked in_last closes the set (even if dropped) and samples the
// sort method register: 0 bubble, 1 selection, 2 insertion, 3 invalid (set
// emitted in arrival order with out_method_invalid raised). While sorting
// and emitting, in_stall stays high. Timing is set by the element memory,
// which has two registered read ports and one write port: a bubble or
// selection step reads a pair, compares it and, if out of order, writes
// both back swapped; insertion loads each element, then reads each lower
// neighbour and shifts it up or places the element (at once at the front).
// Each result is read, loaded and presented until out_stall is low.
// The three methods give identical results; only latency differs.
// ----------------------------------------------------------------------------
`default_nettype none

module array_sorter_three_methods
  import ast_pkg::*;
#(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input beats
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [ELEM_W-1:0] in_value,
  input  wire logic                     in_last,
  // result beats
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [ELEM_W-1:0]      out_sorted_value,
  output logic                          out_end_of_set,
  output logic                          out_method_invalid,
  output logic                          out_overflowed,
  // sort method register
  input  wire logic                     cfg_wr_en,
  input  wire logic [METHOD_W-1:0]      cfg_wr_data
);

  localparam int AW = $clog2(MAX_ELEMS);

  ast_cmd_t       cmd;
  logic [AW-1:0]  rd_a_addr;
  logic [AW-1:0]  rd_b_addr;
  logic [AW-1:0]  wr_addr;
  logic           a_gt_b;

  // Sequencer: load, sort passes and emit order.
  ast_ctrl #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last     (in_last),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .a_gt_b      (a_gt_b),
    .cmd         (cmd),
    .rd_a_addr   (rd_a_addr),
    .rd_b_addr   (rd_b_addr),
    .wr_addr     (wr_addr)
  );

  // Memory, compare and result register.
  ast_datapath #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_datapath (
    .clk                (clk),
    .cmd                (cmd),
    .rd_a_addr          (rd_a_addr),
    .rd_b_addr          (rd_b_addr),
    .wr_addr            (wr_addr),
    .in_value           (in_value),
    .a_gt_b             (a_gt_b),
    .out_sorted_value   (out_sorted_value),
    .out_end_of_set     (out_end_of_set),
    .out_method_invalid (out_method_invalid),
    .out_overflowed     (out_overflowed)
  );

endmodule

`default_nettype wire

// File: tb/sorted_stream_checker.sv
// ----------------------------------------------------------------------------
// sorted_stream_checker
// Watches the element and result channels and checks every result beat.
// ----------------------------------------------------------------------------
// Tracks the sort method register from the write port. Collects each open set
// from the accepted input beats and drops beats beyond capacity. On the
// closing beat it orders the set, or keeps arrival order for the invalid
// method, and queues the result beats it expects. Each accepted result beat
// is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_stream_checker
  import ast_pkg::*;
#(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic                     in_stall,
  input  wire logic signed [ELEM_W-1:0] in_value,
  input  wire logic                     in_last,
  input  wire logic                     out_valid,
  input  wire logic                     out_stall,
  input  wire logic signed [ELEM_W-1:0] out_sorted_value,
  input  wire logic                     out_end_of_set,
  input  wire logic                     out_method_invalid,
  input  wire logic                     out_overflowed,
  input  wire logic                     cfg_wr_en,
  input  wire logic [METHOD_W-1:0]      cfg_wr_data,
  output int                            mismatch_count,
  output int                            results_pending
);

  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     end_mark;
    logic                     invalid;
    logic                     dropped;
  } sorted_beat_t;

  sorted_beat_t             sorted_backlog[$];
  logic signed [ELEM_W-1:0] open_set[$];
  logic                     open_set_dropped;
  method_t                  method_reg;
  int                       fail_tally;

  initial begin
    mismatch_count   = 0;
    results_pending  = 0;
    fail_tally       = 0;
    open_set_dropped = 1'b0;
    method_reg       = METH_BUBBLE;
  end

  always @(posedge clk) begin : predict
    logic signed [ELEM_W-1:0] held;
    sorted_beat_t             want;
    int                       n;
    int                       pos;
    if (!rst_n) begin
      sorted_backlog.delete();
      open_set.delete();
      open_set_dropped = 1'b0;
      method_reg       = METH_BUBBLE;
    end else begin
      if (cfg_wr_en) begin
        method_reg = method_t'(cfg_wr_data);
      end

      if (out_valid && !out_stall) begin
        if (sorted_backlog.size() == 0) begin
          $error("result beat with none expected: sorted_value %0d", out_sorted_value);
          fail_tally++;
        end else begin
          want = sorted_backlog.pop_front();
          if (out_sorted_value !== want.value) begin
            $error("sorted_value: expected %0d, got %0d", want.value, out_sorted_value);
            fail_tally++;
          end
          if (out_end_of_set !== want.end_mark) begin
            $error("end_of_set: expected %0b, got %0b", want.end_mark, out_end_of_set);
            fail_tally++;
          end
          if (out_method_invalid !== want.invalid) begin
            $error("method_invalid: expected %0b, got %0b", want.invalid,
                   out_method_invalid);
            fail_tally++;
          end
          if (out_overflowed !== want.dropped) begin
            $error("overflowed: expected %0b, got %0b", want.dropped, out_overflowed);
            fail_tally++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (open_set.size() < MAX_ELEMS) begin
          open_set.insert(open_set.size(), in_value);
        end else begin
          open_set_dropped = 1'b1;
        end
        if (in_last) begin
          n = open_set.size();
          // Every valid method ends in the same ascending order.
          if (method_reg != METH_INVALID) begin
            for (int a = 1; a < n; a++) begin
              held = open_set[a];
              pos  = a;
              while (pos > 0 && open_set[pos-1] > held) begin
                open_set[pos] = open_set[pos-1];
                pos--;
              end
              open_set[pos] = held;
            end
          end
          for (int k = 0; k < n; k++) begin
            want.value    = open_set[k];
            want.end_mark = (k == n - 1);
            want.invalid  = (method_reg == METH_INVALID);
            want.dropped  = open_set_dropped;
            sorted_backlog.insert(sorted_backlog.size(), want);
          end
          open_set.delete();
          open_set_dropped = 1'b0;
        end
      end
    end
    mismatch_count  <= fail_tally;
    results_pending <= sorted_backlog.size();
  end

endmodule

// File: tb/array_sorter_three_methods_tb.sv
// ----------------------------------------------------------------------------
// array_sorter_three_methods_tb
// Stimulus and verdict for the three-method array sorter.
// ----------------------------------------------------------------------------
// Sends a short directed run of sets (field extremes, a single-element set,
// duplicates, ordered and reversed sets, every method), then random sets
// under four idling modes with a different method in each, then one
// overflowing set. A checker beside the block predicts and compares all
// result beats; this module only drives beats, writes the method register
// and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module array_sorter_three_methods_tb;
  import ast_pkg::*;

  localparam int MAX_ELEMS   = MAX_ELEMS_DEF;
  // QUIET_LIMIT must outlast a bubble sort of a full set, when no beat moves.
  localparam int QUIET_LIMIT = 40000;
  localparam int LONG_HOLD   = 600;
  localparam int SETTLE      = 12;
  localparam int PHASE_ITEMS = 4;

  logic                     clk                = 1'b0;
  logic                     rst_n              = 1'b0;
  logic                     in_valid           = 1'b0;
  logic                     in_stall;
  logic signed [ELEM_W-1:0] in_value           = '0;
  logic                     in_last            = 1'b0;
  logic                     out_valid;
  logic                     out_stall          = 1'b0;
  logic signed [ELEM_W-1:0] out_sorted_value;
  logic                     out_end_of_set;
  logic                     out_method_invalid;
  logic                     out_overflowed;
  logic                     cfg_wr_en          = 1'b0;
  logic [METHOD_W-1:0]      cfg_wr_data        = METH_BUBBLE;

  int   mismatch_count;
  int   results_pending;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_request   = 1'b0;
  int   quiet_cycles;

  always #5 clk = ~clk;

  array_sorter_three_methods #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_value          (in_value),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sorted_value  (out_sorted_value),
    .out_end_of_set    (out_end_of_set),
    .out_method_invalid(out_method_invalid),
    .out_overflowed    (out_overflowed),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  sorted_stream_checker #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_value          (in_value),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sorted_value  (out_sorted_value),
    .out_end_of_set    (out_end_of_set),
    .out_method_invalid(out_method_invalid),
    .out_overflowed    (out_overflowed),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .mismatch_count    (mismatch_count),
    .results_pending   (results_pending)
  );

  // Pick an element: extremes, a narrow band for duplicates, or any word.
  function automatic logic signed [ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Offer one beat after a random idle gap; hold it until accepted.
  task automatic push_elem(input logic signed [ELEM_W-1:0] v, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= l;
    do @(posedge clk); while (in_stall);
  endtask

  // Send a set of random elements, marking the final beat as last.
  task automatic send_set(input int count);
    for (int k = 0; k < count; k++) begin
      push_elem(pick_elem(), k == count - 1);
    end
  endtask

  // Pause the sender until every expected beat has come, then let the block
  // settle back to loading.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the method register; call only while the block is idle.
  task automatic set_method(input method_t m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Receiver: stall at random, or hold off for a long stretch on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request <= 1'b0;
        out_stall    <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int sent;
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes and sign boundary, with the method at its reset value.
    push_elem(32'sh7FFF_FFFF, 1'b0);
    push_elem(32'sh8000_0000, 1'b0);
    push_elem(32'sd0, 1'b0);
    push_elem(-32'sd1, 1'b0);
    push_elem(32'sd1, 1'b1);
    drain();
    // Single-element set.
    push_elem(32'sh8000_0000, 1'b1);
    drain();
    // Duplicates under selection.
    set_method(METH_SELECTION);
    push_elem(32'sd5, 1'b0);
    push_elem(32'sd5, 1'b0);
    push_elem(-32'sd5, 1'b0);
    push_elem(32'sd5, 1'b1);
    drain();
    // Reversed, then already ordered, under insertion.
    set_method(METH_INSERTION);
    push_elem(32'sd3, 1'b0);
    push_elem(32'sd2, 1'b0);
    push_elem(32'sd1, 1'b0);
    push_elem(32'sd0, 1'b0);
    push_elem(-32'sd1, 1'b1);
    push_elem(-32'sd2, 1'b0);
    push_elem(-32'sd1, 1'b0);
    push_elem(32'sd0, 1'b0);
    push_elem(32'sd1, 1'b1);
    drain();
    // Invalid method: arrival order with the error flag.
    set_method(METH_INVALID);
    push_elem(32'sd7, 1'b0);
    push_elem(-32'sd7, 1'b0);
    push_elem(32'sh7FFF_FFFF, 1'b0);
    push_elem(32'sh8000_0000, 1'b1);
    drain();

    // Random sets: one phase per idling mode, a different method in each.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      set_method(method_t'(phase));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n = $urandom_range(1, 4);
        send_set(n);
        sent += n;
      end
      if (phase == 0) begin
        // Hold off the receiver and keep offering the next set so the block
        // backs up and stalls its input.
        send_set(4);
        hold_request <= 1'b1;
        send_set(3);
      end
      drain();
    end

    // Overflowing set: the store fills and the last beat is dropped.
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    set_method(METH_SELECTION);
    send_set(MAX_ELEMS + 1);
    drain();

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
